@@ hw/rtl/mf3_pkg.sv @@
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 median filter: frame limits, register
// indexes, and the word passed from the window front end to the sort back end.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = QAW + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_MAX_GREY = 2'd2
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             reload;
        t_pix             reload_val;
    } t_meta;

    typedef struct packed {
        t_pix [8:0] win;
        t_meta      meta;
    } t_work;

endpackage

@@ hw/rtl/mf3_front.sv @@
// ----------------------------------------------------------------------------
// mf3_front
// Pixel intake: raster counters, two line stores, the 3x3 window, and the
// interior test that decides which windows go on to the sorter.
// ----------------------------------------------------------------------------
module mf3_front import mf3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_pix                  i_pixel_in,
    output logic                  o_full,
    input  logic [QCNT_W-1:0]     i_q_count,
    output logic                  o_wr,
    output t_work                 o_work
);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    t_pix                r_max_grey;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_addr;
    t_pix             r_s1_pix;
    logic             r_s1_emit;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_last;
    logic             r_s1_start;
    t_pix             r_s1_grey;
    logic             r_s1_byp;
    t_pix             r_byp_top;
    t_pix             r_byp_mid;

    t_pix r_rd_upper;
    t_pix r_rd_middle;
    t_pix mem_upper  [MAX_WIDTH];
    t_pix mem_middle [MAX_WIDTH];

    t_pix [8:0] r_win, n_win;
    logic       r_rl_pend;
    t_pix       r_rl_val;

    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    logic [COL_W-1:0]    wm1;
    logic [ROW_W-1:0]    hm1;
    logic [QCNT_W:0]     occ;
    logic                accept;
    logic                emit;
    t_pix                s1_top;
    t_pix                s1_mid;

    // effective frame size
    always_comb begin
        if (r_width == '0) begin
            w = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w = WIDTH_W'(MAX_WIDTH);
        end else begin
            w = r_width;
        end
        if (r_height == '0) begin
            h = HEIGHT_W'(1);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h = r_height;
        end
    end

    assign wm1 = COL_W'(w - WIDTH_W'(1));
    assign hm1 = ROW_W'(h - HEIGHT_W'(1));

    assign occ    = {1'b0, i_q_count} + (QCNT_W+1)'(r_s1_valid);
    assign o_full = occ >= (QCNT_W+1)'(QDEPTH);
    assign accept = i_push && !o_full;

    assign emit = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2)) &&
                  (WIDTH_W'(r_col) < w) && (HEIGHT_W'(r_row) < h);

    always_comb begin
        if (r_col >= wm1) begin
            n_col = '0;
            n_row = (r_row >= hm1) ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_W'(1024);
            r_height   <= HEIGHT_W'(768);
            r_max_grey <= 8'hFF;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_WIDTH:    r_width    <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[HEIGHT_W-1:0];
                REG_MAX_GREY: r_max_grey <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // counters and stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_rl_pend  <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_s1_valid && r_s1_start) begin
                r_rl_pend <= 1'b1;
            end else if (o_wr) begin
                r_rl_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= r_col;
            r_s1_pix   <= i_pixel_in;
            r_s1_emit  <= emit;
            r_s1_row   <= r_row - ROW_W'(1);
            r_s1_col   <= r_col - COL_W'(1);
            r_s1_last  <= (r_col == wm1) && (r_row == hm1);
            r_s1_start <= (r_row == '0) && (r_col == '0);
            r_s1_grey  <= r_max_grey;
            r_s1_byp   <= r_s1_valid && (r_s1_addr == r_col);
            r_byp_top  <= s1_mid;
            r_byp_mid  <= r_s1_pix;
        end
        if (r_s1_valid && r_s1_start) begin
            r_rl_val <= r_s1_grey;
        end
    end

    // line stores, read at intake, written back on the following cycle
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_upper[r_s1_addr] <= s1_mid;
        end
        if (accept) begin
            r_rd_upper <= mem_upper[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_middle[r_s1_addr] <= r_s1_pix;
        end
        if (accept) begin
            r_rd_middle <= mem_middle[r_col];
        end
    end

    assign s1_top = r_s1_byp ? r_byp_top : r_rd_upper;
    assign s1_mid = r_s1_byp ? r_byp_mid : r_rd_middle;

    // window shift
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = s1_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = s1_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_wr                   = r_s1_valid && r_s1_emit;
    assign o_work.win             = n_win;
    assign o_work.meta.row        = r_s1_row;
    assign o_work.meta.col        = r_s1_col;
    assign o_work.meta.last       = r_s1_last;
    assign o_work.meta.reload     = r_rl_pend;
    assign o_work.meta.reload_val = r_rl_val;

endmodule

@@ hw/rtl/mf3_queue.sv @@
// ----------------------------------------------------------------------------
// mf3_queue
// Short queue of windows between the front end and the sorter.
// ----------------------------------------------------------------------------
module mf3_queue import mf3_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  t_work             i_data,
    output logic [QCNT_W-1:0] o_count,
    output logic              o_valid,
    output t_work             o_data,
    input  logic              i_rd
);

    t_work            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic             do_rd;

    assign o_count = r_count;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (i_wr && !do_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_wr && do_rd) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/mf3_back.sv @@
// ----------------------------------------------------------------------------
// mf3_back
// Three-stage median of nine (sort triples, combine, final median) with the
// per-frame running maximum and the result register.
// ----------------------------------------------------------------------------
module mf3_back import mf3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_work            i_work,
    output logic             o_rd,
    output logic             o_empty,
    input  logic             i_pop,
    output t_pix             o_median_out,
    output logic [ROW_W-1:0] o_out_row,
    output logic [COL_W-1:0] o_out_col,
    output t_pix             o_running_max,
    output logic             o_frame_last
);

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic       r_b1_valid;
    t_pix [2:0] r_b1_lo, r_b1_md, r_b1_hi;
    t_meta      r_b1_meta;

    logic       r_b2_valid;
    t_pix       r_b2_a, r_b2_b, r_b2_c;
    t_meta      r_b2_meta;

    logic       r_b3_valid;
    t_pix       r_max;

    logic rdy1, rdy2, rdy3;
    t_pix med, base, n_max;

    assign rdy3 = !r_b3_valid || i_pop;
    assign rdy2 = !r_b2_valid || rdy3;
    assign rdy1 = !r_b1_valid || rdy2;
    assign o_rd = i_valid && rdy1;

    assign med   = med3(r_b2_a, r_b2_b, r_b2_c);
    assign base  = r_b2_meta.reload ? r_b2_meta.reload_val : r_max;
    assign n_max = max2(base, med);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_max      <= 8'hFF;
        end else begin
            if (rdy1) begin
                r_b1_valid <= i_valid;
            end
            if (rdy2) begin
                r_b2_valid <= r_b1_valid;
            end
            if (rdy3) begin
                r_b3_valid <= r_b2_valid;
            end
            if (rdy3 && r_b2_valid) begin
                r_max <= n_max;
            end
        end
    end

    // stage one: order each column
    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            for (int k = 0; k < 3; k++) begin
                r_b1_lo[k] <= min2(min2(i_work.win[k], i_work.win[k+3]), i_work.win[k+6]);
                r_b1_hi[k] <= max2(max2(i_work.win[k], i_work.win[k+3]), i_work.win[k+6]);
                r_b1_md[k] <= med3(i_work.win[k], i_work.win[k+3], i_work.win[k+6]);
            end
            r_b1_meta <= i_work.meta;
        end
    end

    // stage two: max of lows, median of middles, min of highs
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_b1_valid) begin
            r_b2_a    <= max2(max2(r_b1_lo[0], r_b1_lo[1]), r_b1_lo[2]);
            r_b2_b    <= med3(r_b1_md[0], r_b1_md[1], r_b1_md[2]);
            r_b2_c    <= min2(min2(r_b1_hi[0], r_b1_hi[1]), r_b1_hi[2]);
            r_b2_meta <= r_b1_meta;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (rdy3 && r_b2_valid) begin
            o_median_out  <= med;
            o_running_max <= n_max;
            o_out_row     <= r_b2_meta.row;
            o_out_col     <= r_b2_meta.col;
            o_frame_last  <= r_b2_meta.last;
        end
    end

    assign o_empty = !r_b3_valid;

endmodule

@@ hw/rtl/median_filter_3x3_top.sv @@
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// 3x3 median filter over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while full is low and gives, for every interior
// pixel, the median of its 3x3 neighbourhood with its row and column, a running
// maximum that starts from max_grey at each frame, and a last flag on the final
// interior pixel; border pixels give no word. Sustained rate is one pixel per
// cycle while results are popped, set by the line stores, which are read once
// and written once per pixel on separate ports. A pushed pixel passes the line
// store and window register, the queue, and the column sort, combine and
// result registers; with no stalls the first sort stage loads from the queue
// head in the cycle after the queue is written. The user must write frame size
// and max_grey only while the block is idle, which the block does not enforce;
// sizes beyond 1024 columns or 4096 rows are clamped, and a zero acts as one.
module median_filter_3x3_top import mf3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      o_median_out,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [COL_W-1:0]      o_out_col,
    output logic [PIX_W-1:0]      o_running_max,
    output logic                  o_frame_last
);

    logic              q_wr;
    t_work             q_in;
    logic [QCNT_W-1:0] q_count;
    logic              q_valid;
    t_work             q_out;
    logic              q_rd;

    mf3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_pixel_in (i_pixel_in),
        .o_full     (full),
        .i_q_count  (q_count),
        .o_wr       (q_wr),
        .o_work     (q_in)
    );

    mf3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .o_count (q_count),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_rd    (q_rd)
    );

    mf3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_work        (q_out),
        .o_rd          (q_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_median_out  (o_median_out),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_running_max (o_running_max),
        .o_frame_last  (o_frame_last)
    );

endmodule
